// ----- rtl/hcbp_pkg.sv -----
// Shared types and constants for the Huffman code bit packer.
package hcbp_pkg;

  localparam int BYTE_W          = 8;
  localparam int CODE_W          = 32;
  localparam int LEN_IN_W        = 6;
  localparam int SYM_W           = 8;
  localparam int TABLE_DEPTH     = 256;
  localparam int MAX_CODE_BITS_D = 32;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_ENCODE = 2'd1,
    OP_FLUSH  = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef struct packed {
    logic [1:0]          opcode;
    logic [SYM_W-1:0]    symbol;
    logic [CODE_W-1:0]   code_value;
    logic [LEN_IN_W-1:0] code_length;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] packed_byte;
    logic              last_of_run;
  } out_item_t;

endpackage

// ----- rtl/hcbp_if.sv -----
// Valid/ready channel interfaces for the input and result items.
interface hcbp_in_if;
  import hcbp_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface hcbp_out_if;
  import hcbp_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/huffman_code_bit_packer.sv -----
// Huffman code bit packer: code table, byte packing sequencer and output register.
// Load: table written on acceptance. Flush: the flush state writes 1 result to the output register.
// Encode: accept, table read, then the chunk steps, at most ceil(len/8)+1
//   steps; one shared shifter takes up to 8 bits a cycle while no held result stalls it.
// Results appear in the cycle after the step that completes them; a held result stalls steps.
// Reset (rst_n low, synchronous) empties the accumulator and output; table stays unknown.
module huffman_code_bit_packer #(
  parameter int MAX_CODE_BITS = hcbp_pkg::MAX_CODE_BITS_D
) (
  input  logic              clk,
  input  logic              rst_n,
  hcbp_in_if.sink           in_chan,
  hcbp_out_if.source        out_chan
);
  import hcbp_pkg::*;

  // length field width, enough to hold MAX_CODE_BITS itself
  localparam int LenW = $clog2(MAX_CODE_BITS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_RUN,
    S_FLUSH
  } state_t;

  // code table: value and saturated length per symbol
  logic [CODE_W-1:0] tbl_val [TABLE_DEPTH];
  logic [LenW-1:0]   tbl_len [TABLE_DEPTH];
  logic [CODE_W-1:0] rd_val_r;
  logic [LenW-1:0]   rd_len_r;

  state_t            state_r, state_nxt;
  logic [BYTE_W-1:0] acc_r, acc_nxt;      // pending bits, right aligned
  logic [3:0]        free_r, free_nxt;    // free places in current byte, 1..8
  logic [CODE_W-1:0] val_r, val_nxt;      // code under work
  logic [LenW-1:0]   rem_r, rem_nxt;      // code bits still to place
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;

  logic              in_fire;
  logic              slot_free;
  logic              wr_en;
  logic [6:0]        len_in;
  logic [LenW-1:0]   len_sat;

  // shared step unit
  logic [3:0]          k;
  logic [LenW-1:0]     pos;
  logic [CODE_W-1:0]   shifted;
  logic [8:0]          mask;
  logic [2*BYTE_W-1:0] acc_wide;
  logic [BYTE_W-1:0]   acc_step;
  logic [3:0]          free_step;
  logic [LenW-1:0]     rem_step;
  logic [2*BYTE_W-1:0] flush_wide;

  // no item is taken while reset is held
  assign in_chan.ready  = rst_n && (state_r == S_IDLE);
  assign in_fire        = in_chan.valid && in_chan.ready;
  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;
  assign slot_free      = !out_valid_r || out_chan.ready;

  // load-time saturation of the length to the table bound
  assign len_in  = {1'b0, in_chan.data.code_length};
  assign len_sat = (len_in > 7'(MAX_CODE_BITS)) ? LenW'(MAX_CODE_BITS) : LenW'(len_in);
  assign wr_en   = in_fire && (in_chan.data.opcode == OP_LOAD);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tbl_val[in_chan.data.symbol] <= in_chan.data.code_value;
      tbl_len[in_chan.data.symbol] <= len_sat;
    end
    rd_val_r <= tbl_val[in_chan.data.symbol];
    rd_len_r <= tbl_len[in_chan.data.symbol];
  end

  // one chunk: take min(free, rem) bits from the top of the remaining code
  always_comb begin
    k          = (rem_r < LenW'(free_r)) ? rem_r[3:0] : free_r;
    pos        = rem_r - LenW'(k);
    shifted    = val_r >> pos;           // positions beyond the value read as zero
    mask       = (9'd1 << k) - 9'd1;
    acc_wide   = {{BYTE_W{1'b0}}, acc_r} << k;
    acc_step   = acc_wide[BYTE_W-1:0] | (shifted[BYTE_W-1:0] & mask[BYTE_W-1:0]);
    free_step  = free_r - k;
    rem_step   = rem_r - LenW'(k);
    flush_wide = {{BYTE_W{1'b0}}, acc_r} << free_r;
  end

  always_comb begin
    state_nxt     = state_r;
    acc_nxt       = acc_r;
    free_nxt      = free_r;
    val_nxt       = val_r;
    rem_nxt       = rem_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_chan.data.opcode)
            OP_ENCODE: state_nxt = S_LOOK;
            OP_FLUSH:  state_nxt = S_FLUSH;
            default:   state_nxt = S_IDLE;   // load and unused code
          endcase
        end
      end
      S_LOOK: begin
        val_nxt   = rd_val_r;
        rem_nxt   = rd_len_r;
        state_nxt = (rd_len_r == '0) ? S_IDLE : S_RUN;
      end
      S_RUN: begin
        if (slot_free) begin
          rem_nxt = rem_step;
          if (free_step == 4'd0) begin
            out_valid_nxt            = 1'b1;
            out_data_nxt.packed_byte = acc_step;
            // after a full byte, fewer than 8 bits left cannot fill another
            out_data_nxt.last_of_run = (rem_step < LenW'(BYTE_W));
            acc_nxt                  = '0;
            free_nxt                 = 4'(BYTE_W);
          end else begin
            acc_nxt  = acc_step;
            free_nxt = free_step;
          end
          if (rem_step == '0) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_FLUSH: begin
        if (slot_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.packed_byte = flush_wide[BYTE_W-1:0];
          out_data_nxt.last_of_run = 1'b1;
          acc_nxt                  = '0;
          free_nxt                 = 4'(BYTE_W);
          state_nxt                = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      acc_r       <= '0;
      free_r      <= 4'(BYTE_W);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      acc_r       <= acc_nxt;
      free_r      <= free_nxt;
      out_valid_r <= out_valid_nxt;
    end
    val_r      <= val_nxt;
    rem_r      <= rem_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ----- test/tb_huffman_code_bit_packer.sv -----
// Self-checking testbench for the Huffman code bit packer.
module tb_huffman_code_bit_packer;
  import hcbp_pkg::*;

  localparam int MAX_BITS    = MAX_CODE_BITS_D;
  localparam int RAND_ITEMS  = 450;
  // Watchdog bound on the whole run, with plenty of margin over the slowest legal run.
  localparam int CYCLE_LIMIT = 200000;
  // Drain after the last owed byte, well past the longest encode to the output register.
  localparam int DRAIN_CYCLES = 32;

  logic clk;
  logic rst_n;

  hcbp_in_if  in_bus ();
  hcbp_out_if out_bus ();

  huffman_code_bit_packer uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus)
  );

  // Items waiting to be offered, filled once at time zero.
  in_item_t    stim_q[$];
  int unsigned total_items;
  int unsigned accepted_cnt;
  int unsigned err_count;
  int unsigned cycle_cnt;

  // Bookkeeping for stimulus generation: only loaded symbols may be encoded.
  bit         sym_loaded[TABLE_DEPTH];
  logic [7:0] loaded_syms[$];

  // Predictor state: its own copy of the code table and the packing register.
  logic [CODE_W-1:0] code_val_m[TABLE_DEPTH];
  int unsigned       code_len_m[TABLE_DEPTH];
  logic [7:0]        acc_m;
  int unsigned       free_m;

  // Bytes the block owes us, oldest first.
  out_item_t expected_bytes[$];

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_item(input opcode_t op, input logic [7:0] sym,
                            input logic [31:0] val, input logic [5:0] len);
    in_item_t it;
    it.opcode      = op;
    it.symbol      = sym;
    it.code_value  = val;
    it.code_length = len;
    stim_q.push_back(it);
    if (op == OP_LOAD && !sym_loaded[sym]) begin
      sym_loaded[sym] = 1'b1;
      loaded_syms.push_back(sym);
    end
  endtask

  // Mostly short codes, some long, a few zero-length and a few above the bound
  function automatic logic [5:0] rand_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5)  return 6'd0;
    if (r < 75) return 6'($urandom_range(1, 10));
    if (r < 90) return 6'($urandom_range(11, 32));
    return 6'($urandom_range(33, 63));
  endfunction

  // Three idling phases by progress: receiver-heavy, sender-heavy, then none
  function automatic int unsigned run_phase();
    if (accepted_cnt * 3 < total_items)     return 0;
    if (accepted_cnt * 3 < total_items * 2) return 1;
    return 2;
  endfunction

  function automatic int unsigned tx_idle_pct();
    case (run_phase())
      0:       return 38;
      1:       return 50;
      default: return 0;
    endcase
  endfunction

  function automatic int unsigned rx_idle_pct();
    case (run_phase())
      0:       return 50;
      1:       return 38;
      default: return 0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Predictor: updates the model state for one accepted item and queues the
  // bytes it should produce. Bits go in MSB first; a byte leaves when full.
  // ---------------------------------------------------------------------------
  task automatic pack_predict(input in_item_t it);
    logic [63:0] cval;
    int unsigned clen;
    out_item_t   res;
    out_item_t   emitted[$];
    case (opcode_t'(it.opcode))
      OP_LOAD: begin
        clen = it.code_length;
        if (clen > MAX_BITS) clen = MAX_BITS;   // saturate over-long lengths
        code_val_m[it.symbol] = it.code_value;
        code_len_m[it.symbol] = clen;
      end
      OP_ENCODE: begin
        cval = {32'd0, code_val_m[it.symbol]};  // positions past bit 31 read as zero
        clen = code_len_m[it.symbol];
        for (int p = clen; p > 0; p--) begin
          acc_m  = {acc_m[6:0], cval[p-1]};
          free_m = free_m - 1;
          if (free_m == 0) begin
            res.packed_byte = acc_m;
            res.last_of_run = 1'b0;
            emitted.push_back(res);
            acc_m  = '0;
            free_m = 8;
          end
        end
        // zero-length codes and partial bytes leave nothing to mark
        if (emitted.size() > 0) emitted[emitted.size()-1].last_of_run = 1'b1;
        foreach (emitted[i]) expected_bytes.push_back(emitted[i]);
      end
      OP_FLUSH: begin
        // pad pending bits with zeros on the right; empty accumulator gives 0x00
        res.packed_byte = acc_m << free_m;
        res.last_of_run = 1'b1;
        expected_bytes.push_back(res);
        acc_m  = '0;
        free_m = 8;
      end
      default: ;  // spare opcode: ignored
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers the next queued item, holding it until accepted.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else if (!in_bus.valid || in_bus.ready) begin
      if (stim_q.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct()) begin
        in_bus.data  <= stim_q.pop_front();
        in_bus.valid <= 1'b1;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= ($urandom_range(0, 99) >= rx_idle_pct());
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each output byte against the oldest expectation, then
  // feeds any accepted input item to the predictor. A result can never leave
  // in the same cycle as its own input, so the order here is safe.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (out_bus.valid && out_bus.ready) begin
        if (expected_bytes.size() == 0) begin
          $error("unexpected byte: packed_byte %02h, last_of_run %0b",
                 out_bus.data.packed_byte, out_bus.data.last_of_run);
          err_count++;
        end else begin
          want = expected_bytes.pop_front();
          if (out_bus.data.packed_byte !== want.packed_byte) begin
            $error("packed_byte: expected %02h, actual %02h",
                   want.packed_byte, out_bus.data.packed_byte);
            err_count++;
          end
          if (out_bus.data.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %0b, actual %0b",
                   want.last_of_run, out_bus.data.last_of_run);
            err_count++;
          end
        end
      end
      if (in_bus.valid && in_bus.ready) begin
        pack_predict(in_bus.data);
        accepted_cnt <= accepted_cnt + 1;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("huffman_code_bit_packer verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned counted;
    int unsigned r;
    in_bus.valid  = 1'b0;
    in_bus.data   = '0;
    out_bus.ready = 1'b0;
    rst_n         = 1'b0;
    accepted_cnt  = 0;
    err_count     = 0;
    cycle_cnt     = 0;
    acc_m         = '0;
    free_m        = 8;
    foreach (code_val_m[i]) begin
      code_val_m[i] = '0;
      code_len_m[i] = 0;
    end

    // Directed: zero-length code, flush of an empty accumulator
    queue_item(OP_LOAD,   8'd0,   32'h1234_5678, 6'd0);
    queue_item(OP_ENCODE, 8'd0,   $urandom, 6'($urandom));
    queue_item(OP_FLUSH,  8'd0,   $urandom, 6'($urandom));
    // full-width code of all ones: four bytes, last on the fourth
    queue_item(OP_LOAD,   8'd255, 32'hFFFF_FFFF, 6'd32);
    queue_item(OP_ENCODE, 8'd255, $urandom, 6'($urandom));
    // length field at its top, saturated to the bound
    queue_item(OP_LOAD,   8'd1,   32'h0000_0001, 6'd63);
    queue_item(OP_ENCODE, 8'd1,   $urandom, 6'($urandom));
    // short code that fills no byte, spare opcode in between, then padded flush
    queue_item(OP_LOAD,   8'd2,   32'h0000_0005, 6'd3);
    queue_item(OP_ENCODE, 8'd2,   $urandom, 6'($urandom));
    queue_item(OP_NONE,   8'hFF,  32'hFFFF_FFFF, 6'h3F);
    queue_item(OP_ENCODE, 8'd2,   $urandom, 6'($urandom));
    queue_item(OP_FLUSH,  8'hFF,  $urandom, 6'($urandom));
    // long codes straddling byte boundaries with seven bits pending
    queue_item(OP_LOAD,   8'd3,   32'hAAAA_AAAA, 6'd33);
    queue_item(OP_LOAD,   8'd4,   32'h0000_0055, 6'd7);
    queue_item(OP_ENCODE, 8'd4,   $urandom, 6'($urandom));
    queue_item(OP_ENCODE, 8'd3,   $urandom, 6'($urandom));
    queue_item(OP_ENCODE, 8'd255, $urandom, 6'($urandom));
    queue_item(OP_FLUSH,  8'd0,   $urandom, 6'($urandom));
    queue_item(OP_LOAD,   8'd128, 32'h8000_0000, 6'd32);
    queue_item(OP_ENCODE, 8'd2,   $urandom, 6'($urandom));
    queue_item(OP_ENCODE, 8'd128, $urandom, 6'($urandom));
    // overwrite an existing entry
    queue_item(OP_LOAD,   8'd2,   32'h0000_0000, 6'd1);
    queue_item(OP_ENCODE, 8'd2,   $urandom, 6'($urandom));
    queue_item(OP_FLUSH,  8'd0,   $urandom, 6'($urandom));
    queue_item(OP_NONE,   8'd0,   32'd0, 6'd0);

    // Random: loads interleaved with encodes of loaded symbols, some flushes
    counted = 0;
    while (counted < RAND_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 18) begin
        queue_item(OP_LOAD, 8'($urandom), $urandom, rand_len());
        counted++;
      end else if (r < 85) begin
        queue_item(OP_ENCODE, loaded_syms[$urandom_range(0, loaded_syms.size() - 1)],
                   $urandom, 6'($urandom));
        counted++;
      end else if (r < 95) begin
        queue_item(OP_FLUSH, 8'($urandom), $urandom, 6'($urandom));
        counted++;
      end else begin
        queue_item(OP_NONE, 8'($urandom), $urandom, 6'($urandom));
      end
    end
    total_items = stim_q.size();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every item to go in and every owed byte to come out
    while (!(accepted_cnt == total_items && expected_bytes.size() == 0))
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_count == 0 && expected_bytes.size() == 0) begin
      $display("huffman_code_bit_packer verification clean");
    end else begin
      $display("huffman_code_bit_packer verification failed");
    end
    $finish;
  end

endmodule
